// ===== rtl/servo_enable_sequencer_top_defines.svh =====
// Assertion macros shared by the servo enable sequencer RTL.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef SERVO_ENABLE_SEQUENCER_TOP_DEFINES_SVH
`define SERVO_ENABLE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define SES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define SES_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ses_pkg.sv =====
// Package for the servo enable sequencer: item types, state and mode codes,
// register indexes and the mode-to-loop-flag map. No dependencies.
package ses_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_BRAKE_ENABLE  = 3'd0;
  localparam cfg_idx_t CFG_BRAKE_HOLD    = 3'd1;
  localparam cfg_idx_t CFG_LOW_SPEED_THR = 3'd2;
  localparam cfg_idx_t CFG_PWR_RDY_DELAY = 3'd3;
  localparam cfg_idx_t CFG_BRAKE_REL_DLY = 3'd4;

  typedef enum logic [2:0] {
    ST_INACTIVE  = 3'd0,
    ST_BRAKE_REL = 3'd1,
    ST_ACTIVE    = 3'd2,
    ST_PREPARE   = 3'd3,
    ST_PWM_OFF   = 3'd4
  } state_t;

  typedef enum logic [1:0] {
    MODE_POSITION = 2'd0,
    MODE_SPEED    = 2'd1,
    MODE_TORQUE   = 2'd2,
    MODE_INVALID  = 2'd3
  } mode_t;

  // bit0 position, bit1 speed, bit2 current
  typedef logic [2:0] loop_flags_t;

  typedef struct packed {
    logic               supply_ready;
    logic               fault_present;
    logic               servo_on;
    logic [1:0]         requested_mode;
    logic signed [31:0] speed_feedback;
  } in_item_t;

  typedef struct packed {
    logic [2:0] machine_state;
    logic       pwm_on;
    logic       brake_released;
    logic       no_alarm;
    logic       servo_ready;
    logic       power_good;
    logic       position_loop_on;
    logic       speed_loop_on;
    logic       current_loop_on;
    logic       sequencer_fault;
    logic [1:0] active_mode;
  } out_item_t;

  function automatic loop_flags_t mode_flags(input logic [1:0] mode);
    loop_flags_t f;
    case (mode)
      MODE_POSITION: f = 3'b111;
      MODE_SPEED:    f = 3'b110;
      MODE_TORQUE:   f = 3'b100;
      default:       f = 3'b000;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/ses_in_if.sv =====
// Input channel of the servo enable sequencer: valid/ready plus one tick item.
// Depends on ses_pkg.
interface ses_in_if;
  logic               valid;
  logic               ready;
  ses_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ses_out_if.sv =====
// Result channel of the servo enable sequencer: valid/ready plus one result item.
// Depends on ses_pkg.
interface ses_out_if;
  logic               valid;
  logic               ready;
  ses_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ses_core.sv =====
// Sequencer core: config registers, power debounce, enable state machine and
// mode/loop-flag state. Updates on step and returns the tick's result. Uses ses_pkg.
`include "servo_enable_sequencer_top_defines.svh"

module ses_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  ses_pkg::cfg_idx_t               cfg_index,
  input  logic [ses_pkg::CfgDataW-1:0]    cfg_data,
  input  logic                            step,
  input  ses_pkg::in_item_t               item,
  output ses_pkg::out_item_t              result
);

  // configuration
  logic        brake_en_r;
  logic [15:0] brake_hold_r;
  logic [30:0] low_spd_thr_r;
  logic [7:0]  pwr_dly_r;
  logic [7:0]  brk_dly_r;

  // sequencer state
  ses_pkg::state_t      state_r, state_nxt;
  logic                 rtr_r, rtr_nxt;
  logic [1:0]           cur_mode_r, cur_mode_nxt;
  logic [1:0]           pend_mode_r, pend_mode_nxt;
  logic [15:0]          step_cnt_r, step_cnt_nxt;
  logic [7:0]           pwr_cnt_r, pwr_cnt_nxt;
  logic                 pg_r, pg_nxt;
  logic                 pwm_r, pwm_nxt;
  logic                 brk_rel_r, brk_rel_nxt;
  ses_pkg::loop_flags_t flags_r, flags_nxt;
  logic                 seq_fault;

  logic        no_alarm, servo_ok, run_req, slow, brk_wait, hold_wait;
  logic [8:0]  pwr_inc;
  logic [15:0] step_inc;
  logic [31:0] spd_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brake_en_r    <= 1'b0;
      brake_hold_r  <= 16'd0;
      low_spd_thr_r <= 31'd1024;
      pwr_dly_r     <= 8'd8;
      brk_dly_r     <= 8'd40;
    end else if (cfg_we) begin
      case (cfg_index)
        ses_pkg::CFG_BRAKE_ENABLE:  brake_en_r    <= cfg_data[0];
        ses_pkg::CFG_BRAKE_HOLD:    brake_hold_r  <= cfg_data[15:0];
        ses_pkg::CFG_LOW_SPEED_THR: low_spd_thr_r <= cfg_data[30:0];
        ses_pkg::CFG_PWR_RDY_DELAY: pwr_dly_r     <= cfg_data[7:0];
        ses_pkg::CFG_BRAKE_REL_DLY: brk_dly_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Power-ready debounce; count one bit wider so a delay of 255 cannot wrap
  always_comb begin
    pwr_cnt_nxt = pwr_cnt_r;
    pg_nxt      = pg_r;
    pwr_inc     = {1'b0, pwr_cnt_r} + 9'd1;
    if (item.supply_ready) begin
      if (!pg_r) begin
        if (pwr_inc > {1'b0, pwr_dly_r}) begin
          pwr_cnt_nxt = 8'd0;
          pg_nxt      = 1'b1;
        end else begin
          pwr_cnt_nxt = pwr_inc[7:0];
        end
      end
    end else begin
      pwr_cnt_nxt = 8'd0;
      pg_nxt      = 1'b0;
    end
  end

  // Most negative speed negates to itself, which as unsigned is 2^31
  assign spd_mag   = item.speed_feedback[31] ? (~item.speed_feedback + 32'd1)
                                             : item.speed_feedback;
  assign slow      = spd_mag < {1'b0, low_spd_thr_r};
  assign no_alarm  = !item.fault_present;
  assign servo_ok  = no_alarm && pg_nxt;
  assign run_req   = servo_ok && item.servo_on;
  assign step_inc  = step_cnt_r + 16'd1;
  assign brk_wait  = (step_cnt_r < {8'd0, brk_dly_r}) && brake_en_r;
  assign hold_wait = brake_en_r && (step_inc < {1'b0, brake_hold_r[15:1]});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ses_pkg::ST_INACTIVE:  if (servo_ok) state_nxt = ses_pkg::ST_BRAKE_REL;
      ses_pkg::ST_BRAKE_REL: if (!brk_wait) state_nxt = ses_pkg::ST_ACTIVE;
      ses_pkg::ST_ACTIVE: begin
        if (!run_req || (item.requested_mode != cur_mode_r)) begin
          state_nxt = ses_pkg::ST_PREPARE;
        end
      end
      ses_pkg::ST_PREPARE: begin
        if (!rtr_r) begin
          state_nxt = ses_pkg::ST_PWM_OFF;
        end else if (slow) begin
          state_nxt = ses_pkg::ST_ACTIVE;
        end else if (run_req && (item.requested_mode == cur_mode_r)) begin
          state_nxt = ses_pkg::ST_ACTIVE;
        end
      end
      ses_pkg::ST_PWM_OFF: begin
        if (!servo_ok || !hold_wait) state_nxt = ses_pkg::ST_INACTIVE;
      end
      default: state_nxt = ses_pkg::ST_INACTIVE;
    endcase
  end

  // register updates and fault pulse
  always_comb begin
    rtr_nxt       = rtr_r;
    cur_mode_nxt  = cur_mode_r;
    pend_mode_nxt = pend_mode_r;
    step_cnt_nxt  = step_cnt_r;
    pwm_nxt       = pwm_r;
    brk_rel_nxt   = brk_rel_r;
    flags_nxt     = flags_r;
    seq_fault     = 1'b0;
    case (state_r)
      ses_pkg::ST_INACTIVE: begin
        if (servo_ok) begin
          rtr_nxt      = 1'b1;
          cur_mode_nxt = item.requested_mode;
          flags_nxt    = ses_pkg::mode_flags(item.requested_mode);
          seq_fault    = (item.requested_mode == ses_pkg::MODE_INVALID);
          step_cnt_nxt = 16'd0;
        end else begin
          flags_nxt = '0;
          rtr_nxt   = 1'b0;
          pwm_nxt   = 1'b0;
        end
      end
      ses_pkg::ST_BRAKE_REL: begin
        pwm_nxt = 1'b1;
        if (brk_wait) begin
          step_cnt_nxt = step_inc;
          brk_rel_nxt  = 1'b0;
        end else begin
          brk_rel_nxt  = 1'b1;
          step_cnt_nxt = 16'd0;
        end
      end
      ses_pkg::ST_ACTIVE: begin
        rtr_nxt = run_req;
        if (run_req) pend_mode_nxt = item.requested_mode;
      end
      ses_pkg::ST_PREPARE: begin
        if (!rtr_r) begin
          step_cnt_nxt = 16'd0;
        end else if (slow) begin
          cur_mode_nxt = pend_mode_r;
          flags_nxt    = ses_pkg::mode_flags(pend_mode_r);
          seq_fault    = (pend_mode_r == ses_pkg::MODE_INVALID);
        end else if (!run_req) begin
          rtr_nxt = 1'b0;
        end else begin
          pend_mode_nxt = item.requested_mode;
        end
      end
      ses_pkg::ST_PWM_OFF: begin
        brk_rel_nxt = 1'b0;
        if (servo_ok && hold_wait) begin
          pwm_nxt      = 1'b1;
          step_cnt_nxt = step_inc;
        end else begin
          pwm_nxt      = 1'b0;
          step_cnt_nxt = 16'd0;
        end
      end
      default: seq_fault = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ses_pkg::ST_INACTIVE;
      rtr_r       <= 1'b0;
      cur_mode_r  <= ses_pkg::MODE_SPEED;
      pend_mode_r <= ses_pkg::MODE_SPEED;
      step_cnt_r  <= 16'd0;
      pwr_cnt_r   <= 8'd0;
      pg_r        <= 1'b0;
      pwm_r       <= 1'b0;
      brk_rel_r   <= 1'b0;
      flags_r     <= '0;
    end else if (step) begin
      state_r     <= state_nxt;
      rtr_r       <= rtr_nxt;
      cur_mode_r  <= cur_mode_nxt;
      pend_mode_r <= pend_mode_nxt;
      step_cnt_r  <= step_cnt_nxt;
      pwr_cnt_r   <= pwr_cnt_nxt;
      pg_r        <= pg_nxt;
      pwm_r       <= pwm_nxt;
      brk_rel_r   <= brk_rel_nxt;
      flags_r     <= flags_nxt;
    end
  end

  always_comb begin
    result.machine_state    = state_nxt;
    result.pwm_on           = pwm_nxt;
    result.brake_released   = brk_rel_nxt;
    result.no_alarm         = no_alarm;
    result.servo_ready      = servo_ok;
    result.power_good       = pg_nxt;
    result.position_loop_on = flags_nxt[0];
    result.speed_loop_on    = flags_nxt[1];
    result.current_loop_on  = flags_nxt[2];
    result.sequencer_fault  = seq_fault;
    result.active_mode      = cur_mode_nxt;
  end

  `SES_ASSERT_NOW(a_brake_needs_pwm, brk_rel_r, pwm_r, "brake released without PWM")
  `SES_ASSERT_NOW(a_pg_cnt_clear, pg_r, pwr_cnt_r == 8'd0, "power counter live after power good")
  `SES_ASSERT_NXT(a_hold_no_step, !step, $stable(state_r) && $stable(step_cnt_r),
                  "sequencer moved without a tick")

endmodule

// ===== rtl/servo_enable_sequencer_top.sv =====
// Channel | dir | payload                         | handshake
// in_if   | in  | ses_pkg::in_item_t (one tick)   | valid/ready
// out_if  | out | ses_pkg::out_item_t (one result)| valid/ready
// cfg_*   | in  | cfg_index 3b, cfg_data 31b      | cfg_we, no stall
//
// One item per cycle sustained while out_if is not stalled; an accepted item is held in the input register
// and then reaches out_if through the result register around ses_core.
// Reset: rst_n synchronous, active low; clears control and the configuration registers.
// A stalled output holds its result; the input register keeps taking items while it is free.
// Depends on ses_pkg, ses_in_if, ses_out_if, ses_core and the defines header.
`include "servo_enable_sequencer_top_defines.svh"

module servo_enable_sequencer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  ses_in_if.sink                       in_if,
  ses_out_if.source                    out_if,
  input  logic                         cfg_we,
  input  ses_pkg::cfg_idx_t            cfg_index,
  input  logic [ses_pkg::CfgDataW-1:0] cfg_data
);

  logic               s1_valid_r;
  ses_pkg::in_item_t  s1_item_r;
  logic               out_valid_r;
  ses_pkg::out_item_t out_item_r;
  ses_pkg::out_item_t core_result;
  logic               advance;
  logic               in_take;

  // the input stage moves into the result register whenever that one is free
  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;
  assign in_take     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) s1_valid_r <= in_if.valid;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_item_r <= in_if.data;
    if (advance) out_item_r <= core_result;
  end

  ses_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (s1_item_r),
    .result    (core_result)
  );

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_item_r;

  `SES_ASSERT_NXT(a_take_fills_s1, in_take, s1_valid_r, "accepted item not held")
  `SES_ASSERT_NXT(a_adv_fills_out, advance, out_valid_r, "advanced item not presented")
  `SES_ASSERT_NXT(a_s1_not_lost, s1_valid_r && !advance, s1_valid_r, "stalled item dropped")

endmodule

// ===== tb/testbench.sv =====
// Testbench for servo_enable_sequencer_top: drives control ticks and register writes,
// predicts every status result in a scoreboard class and checks it field by field.
// Depends on ses_pkg, ses_in_if, ses_out_if and the sequencer RTL.
`timescale 1ns / 100ps

module testbench;
  import ses_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam cfg_idx_t CFG_IDX_TOP = '1;

  // Tracks the sequencer state and holds the status items still owed by the block
  class drive_status_board;
    bit          brake_en;
    bit [15:0]   hold_time;
    bit [30:0]   speed_thr;
    bit [7:0]    pwr_delay;
    bit [7:0]    rel_delay;

    state_t      st;
    bit          run_ok;
    mode_t       cur_mode;
    mode_t       next_mode;
    bit [15:0]   step_cnt;
    bit [7:0]    pwr_cnt;
    bit          pwr_good;
    bit          pwm;
    bit          brake_open;
    loop_flags_t loops;

    out_item_t   status_q[$];
    int          failures;

    function new();
      brake_en   = 1'b0;
      hold_time  = '0;
      speed_thr  = 31'd1024;
      pwr_delay  = 8'd8;
      rel_delay  = 8'd40;
      st         = ST_INACTIVE;
      run_ok     = 1'b0;
      cur_mode   = MODE_SPEED;
      next_mode  = MODE_SPEED;
      step_cnt   = '0;
      pwr_cnt    = '0;
      pwr_good   = 1'b0;
      pwm        = 1'b0;
      brake_open = 1'b0;
      loops      = '0;
      failures   = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] d);
      case (idx)
        CFG_BRAKE_ENABLE:  brake_en  = d[0];
        CFG_BRAKE_HOLD:    hold_time = d[15:0];
        CFG_LOW_SPEED_THR: speed_thr = d[30:0];
        CFG_PWR_RDY_DELAY: pwr_delay = d[7:0];
        CFG_BRAKE_REL_DLY: rel_delay = d[7:0];
        default: ;
      endcase
    endfunction

    // returns 1 when the mode put in force is the invalid one
    function bit set_loops(mode_t m);
      set_loops = 1'b0;
      case (m)
        MODE_POSITION: loops = 3'b111;
        MODE_SPEED:    loops = 3'b110;
        MODE_TORQUE:   loops = 3'b100;
        default: begin
          loops = 3'b000;
          set_loops = 1'b1;
        end
      endcase
    endfunction

    function void note_tick(in_item_t t);
      out_item_t          r;
      logic signed [32:0] sx;
      logic [32:0]        mag;
      logic [8:0]         cnt_next;
      bit                 no_alarm, ok, on_req, slow, seq_fault;
      mode_t              req;
      sx = t.speed_feedback;
      mag = sx[32] ? -sx : sx;
      slow = mag < {2'b00, speed_thr};
      req = mode_t'(t.requested_mode);
      seq_fault = 1'b0;
      no_alarm = !t.fault_present;

      if (t.supply_ready) begin
        if (!pwr_good) begin
          cnt_next = {1'b0, pwr_cnt} + 9'd1;
          if (cnt_next > {1'b0, pwr_delay}) begin
            pwr_cnt = '0;
            pwr_good = 1'b1;
          end else begin
            pwr_cnt = cnt_next[7:0];
          end
        end
      end else begin
        pwr_cnt = '0;
        pwr_good = 1'b0;
      end
      ok = no_alarm && pwr_good;
      on_req = ok && t.servo_on;

      case (st)
        ST_INACTIVE: begin
          if (ok) begin
            run_ok = 1'b1;
            cur_mode = req;
            seq_fault = set_loops(cur_mode);
            step_cnt = '0;
            st = ST_BRAKE_REL;
          end else begin
            loops = '0;
            run_ok = 1'b0;
            pwm = 1'b0;
          end
        end
        ST_BRAKE_REL: begin
          pwm = 1'b1;
          if (step_cnt < rel_delay && brake_en) begin
            step_cnt = step_cnt + 16'd1;
            brake_open = 1'b0;
          end else begin
            brake_open = 1'b1;
            step_cnt = '0;
            st = ST_ACTIVE;
          end
        end
        ST_ACTIVE: begin
          if (on_req) begin
            run_ok = 1'b1;
            next_mode = req;
            if (next_mode != cur_mode) st = ST_PREPARE;
          end else begin
            run_ok = 1'b0;
            st = ST_PREPARE;
          end
        end
        ST_PREPARE: begin
          if (run_ok) begin
            if (slow) begin
              cur_mode = next_mode;
              seq_fault = set_loops(cur_mode);
              st = ST_ACTIVE;
            end else if (!on_req) begin
              run_ok = 1'b0;
            end else begin
              next_mode = req;
              if (next_mode == cur_mode) st = ST_ACTIVE;
            end
          end else begin
            step_cnt = '0;
            st = ST_PWM_OFF;
          end
        end
        ST_PWM_OFF: begin
          brake_open = 1'b0;
          if (!ok) begin
            pwm = 1'b0;
            step_cnt = '0;
            st = ST_INACTIVE;
          end else begin
            step_cnt = step_cnt + 16'd1;
            if (brake_en && step_cnt < (hold_time >> 1)) begin
              pwm = 1'b1;
            end else begin
              pwm = 1'b0;
              step_cnt = '0;
              st = ST_INACTIVE;
            end
          end
        end
        default: begin
          st = ST_INACTIVE;
          seq_fault = 1'b1;
        end
      endcase

      r.machine_state    = st;
      r.pwm_on           = pwm;
      r.brake_released   = brake_open;
      r.no_alarm         = no_alarm;
      r.servo_ready      = ok;
      r.power_good       = pwr_good;
      r.position_loop_on = loops[0];
      r.speed_loop_on    = loops[1];
      r.current_loop_on  = loops[2];
      r.sequencer_fault  = seq_fault;
      r.active_mode      = cur_mode;
      status_q.push_back(r);
    endfunction

    function void check_field(string name, logic [2:0] e, logic [2:0] a);
      if (a !== e) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        failures++;
      end
    endfunction

    function void check_status(out_item_t got);
      out_item_t e;
      if (status_q.size() == 0) begin
        $error("status item with no tick pending");
        failures++;
        return;
      end
      e = status_q.pop_front();
      check_field("machine_state", e.machine_state, got.machine_state);
      check_field("pwm_on", e.pwm_on, got.pwm_on);
      check_field("brake_released", e.brake_released, got.brake_released);
      check_field("no_alarm", e.no_alarm, got.no_alarm);
      check_field("servo_ready", e.servo_ready, got.servo_ready);
      check_field("power_good", e.power_good, got.power_good);
      check_field("position_loop_on", e.position_loop_on, got.position_loop_on);
      check_field("speed_loop_on", e.speed_loop_on, got.speed_loop_on);
      check_field("current_loop_on", e.current_loop_on, got.current_loop_on);
      check_field("sequencer_fault", e.sequencer_fault, got.sequencer_fault);
      check_field("active_mode", e.active_mode, got.active_mode);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_t            cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ses_in_if  in_ch();
  ses_out_if out_ch();

  drive_status_board board;
  bit in_idle;
  bit out_idle;
  int out_hold;
  int ticks_sent;
  int cycle_count;

  servo_enable_sequencer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) board.check_status(out_ch.data);
  end

  // Result side: random stall per item while out_idle is set, plus a long hold when out_hold is set
  initial begin
    int wait_n;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      wait_n = out_hold + (out_idle ? $urandom_range(0, 5) : 0);
      out_hold = 0;
      if (wait_n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_tick(bit sup, bit flt, bit son, mode_t m, logic [31:0] spd);
    in_item_t it;
    int       gap;
    it.supply_ready   = sup;
    it.fault_present  = flt;
    it.servo_on       = son;
    it.requested_mode = m;
    it.speed_feedback = spd;
    gap = in_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    board.note_tick(it);
    ticks_sent++;
  endtask

  // Stop offering ticks until every status item is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    board.write_reg(idx, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(bit be, logic [15:0] hold, logic [30:0] thr,
                               logic [7:0] pdly, logic [7:0] rdly);
    settle();
    write_reg(CFG_BRAKE_ENABLE, CfgDataW'(be));
    write_reg(CFG_BRAKE_HOLD, CfgDataW'(hold));
    write_reg(CFG_LOW_SPEED_THR, thr);
    write_reg(CFG_PWR_RDY_DELAY, CfgDataW'(pdly));
    write_reg(CFG_BRAKE_REL_DLY, CfgDataW'(rdly));
  endtask

  function automatic mode_t pick_mode();
    return ($urandom_range(0, 11) == 0) ? MODE_INVALID : mode_t'($urandom_range(0, 2));
  endfunction

  // Mix of full-range, extreme, near-threshold and small speeds
  function automatic logic [31:0] pick_speed();
    logic [31:0] v;
    int unsigned sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: v = $urandom;
      1: v = 32'h8000_0000;
      2: v = 32'h7FFF_FFFF;
      3: v = {1'b0, board.speed_thr};
      4: v = {1'b0, board.speed_thr} - 32'd1;
      default: v = 32'($urandom_range(0, 4095)) - 32'd2048;
    endcase
    if ((sel == 3 || sel == 4) && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic run_directed();
    send_tick(0, 0, 0, MODE_POSITION, 32'd0);
    send_tick(1, 1, 1, MODE_POSITION, 32'hFFFF_FFFF);
    repeat (7) send_tick(1, 0, 1, MODE_TORQUE, 32'd5);
    // power good now; leaves idle without servo on, invalid mode latched
    send_tick(1, 0, 0, MODE_INVALID, 32'd0);
    send_tick(1, 0, 1, MODE_INVALID, 32'd0);
    send_tick(1, 0, 1, MODE_INVALID, 32'd0);
    send_tick(1, 0, 1, MODE_POSITION, 32'h8000_0000);
    send_tick(1, 0, 1, MODE_POSITION, 32'h8000_0000);
    send_tick(1, 0, 1, MODE_POSITION, 32'h7FFF_FFFF);
    send_tick(1, 0, 1, MODE_POSITION, 32'd1023);
    send_tick(1, 0, 1, MODE_SPEED, 32'd0);
    send_tick(1, 0, 1, MODE_SPEED, -32'sd1023);
    send_tick(1, 0, 1, MODE_TORQUE, 32'd0);
    send_tick(1, 0, 1, MODE_TORQUE, -32'sd1024);
    send_tick(1, 0, 1, MODE_SPEED, 32'd1024);
    // normal shutdown
    repeat (3) send_tick(1, 0, 0, MODE_SPEED, 32'd0);
    send_tick(1, 0, 1, MODE_TORQUE, 32'd0);
    send_tick(1, 0, 1, MODE_TORQUE, 32'd0);
    send_tick(1, 0, 1, MODE_POSITION, 32'h4000_0000);
    // fault while waiting for low speed
    send_tick(1, 1, 1, MODE_POSITION, 32'h4000_0000);
    send_tick(1, 1, 1, MODE_POSITION, 32'd0);
    send_tick(0, 1, 0, MODE_POSITION, 32'd0);
  endtask

  // Power up, run with mode changes, then shut down one of three ways
  task automatic run_session();
    mode_t m;
    int    n;
    int    tries;
    m = pick_mode();
    tries = 0;
    while (board.st == ST_INACTIVE && tries < 300) begin
      send_tick(1, $urandom_range(0, 19) == 0, $urandom_range(0, 1), m, pick_speed());
      tries++;
    end
    n = $urandom_range(3, 40);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) m = pick_mode();
      send_tick($urandom_range(0, 39) != 0, $urandom_range(0, 39) == 0,
                $urandom_range(0, 29) != 0, m, pick_speed());
    end
    n = $urandom_range(1, 12);
    case ($urandom_range(0, 3))
      0, 1: repeat (n) send_tick(1, 0, 0, m, pick_speed());
      2: repeat (n) send_tick(1, 1, $urandom_range(0, 1), m, pick_speed());
      default: repeat (n) send_tick(0, $urandom_range(0, 1), $urandom_range(0, 1), m,
                                    pick_speed());
    endcase
  endtask

  task automatic run_random(int n);
    int stop;
    int unsigned sel;
    stop = ticks_sent + n;
    while (ticks_sent < stop) begin
      sel = $urandom_range(0, 24);
      if (sel == 0) begin
        settle();
      end else if (sel < 4) begin
        repeat ($urandom_range(1, 10))
          send_tick($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                    mode_t'($urandom_range(0, 3)), $urandom);
      end else begin
        run_session();
      end
    end
  endtask

  initial begin
    board = new();
    in_idle = 1'b1;
    out_idle = 1'b1;
    out_hold = 0;
    ticks_sent = 0;
    cycle_count = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    out_ch.ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_BRAKE_ENABLE;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(100);

    apply_setting(1'b1, 16'd10, 31'd1024, 8'd0, 8'd3);
    run_random(40);
    out_hold = 80;
    run_random(80);

    // unused register indexes must have no effect
    settle();
    for (int i = CFG_BRAKE_REL_DLY + 1; i <= CFG_IDX_TOP; i++)
      write_reg(cfg_idx_t'(i), CfgDataW'($urandom));
    apply_setting(1'b1, 16'hFFFF, 31'h7FFF_FFFF, 8'd1, 8'd255);
    in_idle = 1'b0;
    out_idle = 1'b0;
    run_random(120);

    apply_setting(1'b0, 16'd0, 31'd0, 8'd255, 8'd0);
    in_idle = 1'b1;
    run_random(150);

    apply_setting(1'b1, 16'd1, 31'd2000, 8'd2, 8'd0);
    out_idle = 1'b1;
    run_random(120);

    apply_setting(1'b1, 16'd7, 31'd5000, 8'd4, 8'd10);
    in_idle = 1'b0;
    run_random(100);

    settle();
    repeat (6) @(posedge clk);
    if (board.failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
